>>> src/pcan_pkg.sv
package pcan_pkg;

  localparam int MaxComponents = 256;
  localparam int MaxBytes      = 4096;
  localparam int StackAw       = $clog2(MaxComponents);
  localparam int ByteAw        = $clog2(MaxBytes);

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NUL      = 3'd2;
  localparam logic [2:0] ST_ESCAPE   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_TOO_DEEP = 3'd5;
  localparam logic [2:0] ST_BAD      = 3'd6;
  localparam logic [2:0] ST_NONE     = 3'd7;

  localparam logic [1:0] REG_LENGTH_QUOTA = 2'd0;
  localparam logic [1:0] REG_DEPTH_QUOTA  = 2'd1;
  localparam logic [1:0] REG_CAPACITY     = 2'd2;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] path_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] path_length;
    logic [7:0]  out_byte;
    logic        out_last;
  } result_t;

endpackage

>>> src/pcan_front.sv
module pcan_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcan_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output pcan_pkg::item_t q_item
);
  import pcan_pkg::*;

  item_t      slot_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wr_r] <= in_item;
  end

endmodule

>>> src/pcan_core.sv
module pcan_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  pcan_pkg::item_t   q_item,
  input  logic [15:0]       length_quota,
  input  logic [15:0]       depth_quota,
  input  logic [15:0]       output_capacity,
  output logic              res_valid,
  input  logic              res_ready,
  output pcan_pkg::result_t res
);
  import pcan_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_RD2  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [7:0]  bs_mem [MaxBytes];
  logic [24:0] st_mem [MaxComponents];
  logic [7:0]  bs_q;
  logic [24:0] st_q;

  logic [2:0]  state_r, state_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [12:0] taken_r, taken_nxt;
  logic [11:0] cstart_r, cstart_nxt;
  logic [12:0] clen_r, clen_nxt, cdots_r, cdots_nxt;
  logic [2:0]  fwe_r, fwe_nxt;
  logic        nul_r, nul_nxt, done_r, done_nxt;
  logic [8:0]  rent_r, rent_nxt;
  logic [12:0] roff_r, roff_nxt;
  logic [12:0] canon_r, canon_nxt;
  logic [2:0]  dstat_r, dstat_nxt;
  logic [12:0] dlen_r, dlen_nxt;
  logic        after_fin_r, after_fin_nxt;
  result_t     hold_r, hold_nxt, out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic        bs_we, st_we;
  logic [ByteAw-1:0]  bs_wa, bs_ra;
  logic [StackAw-1:0] st_ra;
  logic [24:0] st_wd;

  logic        is_append, is_slash, do_close, close_pop;
  logic [12:0] e_len;
  logic [11:0] e_start;
  logic [ByteAw-1:0] idx;
  logic [16:0] need;
  logic [2:0]  fstat;

  assign e_start = st_q[24:13];
  assign e_len   = st_q[12:0];
  assign idx     = e_start + roff_r[ByteAw-1:0] - 12'd1;
  assign need    = {4'd0, taken_r} + 17'd2;
  assign res_valid = ov_r;
  assign res       = out_r;

  always_comb begin
    if (length_quota != 16'd0 && {3'd0, taken_r} > length_quota) fstat = ST_TOO_LONG;
    else if (output_capacity < 16'd2 || taken_r > 13'(MaxBytes)
             || need > {1'b0, output_capacity}) fstat = ST_TOO_LONG;
    else if (nul_r) fstat = ST_NUL;
    else if (fwe_r != ST_NONE) fstat = fwe_r;
    else if (depth_quota != 16'd0 && {7'd0, cnt_r} > depth_quota) fstat = ST_TOO_DEEP;
    else if (cnt_r == 9'd0) fstat = ST_EMPTY;
    else if (length_quota != 16'd0 && {3'd0, canon_r} > length_quota) fstat = ST_TOO_LONG;
    else fstat = ST_OK;
  end

  always_comb begin
    state_nxt = state_r;   cnt_nxt = cnt_r;     taken_nxt = taken_r;
    cstart_nxt = cstart_r; clen_nxt = clen_r;   cdots_nxt = cdots_r;
    fwe_nxt = fwe_r;       nul_nxt = nul_r;     done_nxt = done_r;
    rent_nxt = rent_r;     roff_nxt = roff_r;   canon_nxt = canon_r;
    dstat_nxt = dstat_r;   dlen_nxt = dlen_r;   after_fin_nxt = after_fin_r;
    hold_nxt = hold_r;     out_nxt = out_r;     ov_nxt = ov_r;
    q_pop = 1'b0; bs_we = 1'b0; st_we = 1'b0;
    bs_wa = taken_r[ByteAw-1:0];
    bs_ra = idx;
    st_wd = {cstart_r, clen_r};
    st_ra = (cnt_r[StackAw-1:0] - 1'b1);
    is_append = (q_item.action == ACT_APPEND);
    is_slash  = (q_item.path_byte == CH_SLASH);
    do_close  = 1'b0;
    close_pop = 1'b0;

    if (ov_r && res_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          hold_nxt = '{status: ST_NONE, path_length: 13'd0, out_byte: 8'd0, out_last: 1'b0};
          if (is_append && done_r) begin
            cnt_nxt = '0; taken_nxt = '0; cstart_nxt = '0; clen_nxt = '0; cdots_nxt = '0;
            fwe_nxt = ST_NONE; nul_nxt = 1'b0; rent_nxt = '0; roff_nxt = '0;
            done_nxt = 1'b0; canon_nxt = '0; dstat_nxt = ST_NONE; dlen_nxt = '0;
          end else begin
            q_pop = 1'b1;
            state_nxt = S_OUT;
            case (q_item.action)
              ACT_APPEND: begin
                if (taken_r >= 13'(MaxBytes)) begin
                  taken_nxt = 13'(MaxBytes + 1);
                end else begin
                  bs_we = 1'b1;
                  if (q_item.path_byte == 8'd0) nul_nxt = 1'b1;
                  if (is_slash) begin
                    do_close = 1'b1;
                  end else begin
                    if (clen_r == 13'd0) cstart_nxt = taken_r[11:0];
                    if (q_item.path_byte == CH_DOT && cdots_r == clen_r)
                      cdots_nxt = cdots_r + 13'd1;
                    clen_nxt = clen_r + 13'd1;
                  end
                  taken_nxt = taken_r + 13'd1;
                end
              end
              ACT_FINISH: begin
                rent_nxt = '0; roff_nxt = '0;
                if (!done_r) begin
                  do_close = 1'b1;
                  after_fin_nxt = 1'b1;
                  state_nxt = S_FIN;
                end else begin
                  hold_nxt.status = dstat_r;
                  hold_nxt.path_length = dlen_r;
                end
              end
              ACT_READ: begin
                st_ra = rent_r[StackAw-1:0];
                if (done_r && dstat_r == ST_OK && rent_r < cnt_r) state_nxt = S_RD1;
              end
              default: ;
            endcase
            if (do_close) begin
              clen_nxt = '0; cdots_nxt = '0;
              if (fwe_r == ST_NONE && clen_r != 13'd0) begin
                if (clen_r == 13'd1 && cdots_r == 13'd1) begin
                end else if (clen_r == 13'd2 && cdots_r == 13'd2) begin
                  if (cnt_r == 9'd0) fwe_nxt = ST_ESCAPE;
                  else close_pop = 1'b1;
                end else if (cdots_r == clen_r) begin
                  fwe_nxt = ST_BAD;
                end else if (cnt_r >= 9'(MaxComponents)) begin
                  fwe_nxt = ST_TOO_DEEP;
                end else begin
                  st_we = 1'b1;
                  cnt_nxt = cnt_r + 9'd1;
                  canon_nxt = canon_r + clen_r + 13'd1;
                end
              end
              if (close_pop) begin
                after_fin_nxt = !is_append;
                state_nxt = S_POP;
              end
            end
          end
        end
      end
      S_POP: begin
        cnt_nxt = cnt_r - 9'd1;
        canon_nxt = canon_r - e_len - 13'd1;
        state_nxt = after_fin_r ? S_FIN : S_OUT;
      end
      S_FIN: begin
        dstat_nxt = fstat;
        dlen_nxt = (fstat == ST_OK) ? canon_r : 13'd0;
        done_nxt = 1'b1;
        after_fin_nxt = 1'b0;
        hold_nxt.status = fstat;
        hold_nxt.path_length = (fstat == ST_OK) ? canon_r : 13'd0;
        state_nxt = S_OUT;
      end
      S_RD1: begin
        hold_nxt.status = ST_OK;
        hold_nxt.out_byte = CH_SLASH;
        if (roff_r >= e_len) begin
          rent_nxt = rent_r + 9'd1;
          roff_nxt = '0;
          hold_nxt.out_last = ((rent_r + 9'd1) == cnt_r);
        end else begin
          roff_nxt = roff_r + 13'd1;
        end
        state_nxt = (roff_r == 13'd0) ? S_OUT : S_RD2;
      end
      S_RD2: begin
        hold_nxt.out_byte = bs_q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || res_ready) begin
          out_nxt = hold_r;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; taken_r <= '0; cstart_r <= '0;
      clen_r <= '0; cdots_r <= '0; fwe_r <= ST_NONE; nul_r <= 1'b0;
      done_r <= 1'b0; rent_r <= '0; roff_r <= '0; canon_r <= '0;
      dstat_r <= ST_NONE; dlen_r <= '0; after_fin_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; taken_r <= taken_nxt;
      cstart_r <= cstart_nxt; clen_r <= clen_nxt; cdots_r <= cdots_nxt;
      fwe_r <= fwe_nxt; nul_r <= nul_nxt; done_r <= done_nxt;
      rent_r <= rent_nxt; roff_r <= roff_nxt; canon_r <= canon_nxt;
      dstat_r <= dstat_nxt; dlen_r <= dlen_nxt; after_fin_r <= after_fin_nxt;
      ov_r <= ov_nxt;
    end
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= q_item.path_byte;
    bs_q <= bs_mem[bs_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[cnt_r[StackAw-1:0]] <= st_wd;
    st_q <= st_mem[st_ra];
  end

endmodule

>>> src/path_canonicalizer.sv
// channel | direction | fields
// in_     | slave     | tuser: action[1:0]; tdata: path_byte[7:0]
// out_    | master    | tuser: status[2:0]; tdata: path_length[12:0], out_byte[20:13]; tlast
// cfg_    | write     | addr: register index; data: 16-bit value
// One transaction per item. A plain append, a repeated finish or a read yielding nothing
// goes straight to output; a '..' that pops adds a pop step; an append after a finish first
// clears the path state; a first finish adds a finish step (after a pop step if it pops);
// a yielding read waits for a stack memory read, plus a byte memory read for a path byte.
// A two-entry input queue decouples the parser from the upstream side; the core holds
// in its output step while a result waits unaccepted. rst_n is synchronous; memories are
// not cleared.
module path_canonicalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [7:0]  in_tdata,   // path_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [23:0] out_tdata,  // path_length, out_byte, zero pad
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import pcan_pkg::*;

  item_t       in_item, q_item;
  logic        q_valid, q_pop;
  result_t     res;
  logic [15:0] lq_r, dq_r, cap_r;

  assign in_item   = '{action: in_tuser, path_byte: in_tdata};
  assign cfg_ready = 1'b1;
  assign out_tuser = res.status;
  assign out_tdata = {3'd0, res.out_byte, res.path_length};
  assign out_tlast = res.out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lq_r  <= 16'd0;
      dq_r  <= 16'd0;
      cap_r <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_LENGTH_QUOTA: lq_r  <= cfg_data;
        REG_DEPTH_QUOTA:  dq_r  <= cfg_data;
        REG_CAPACITY:     cap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pcan_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(in_item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  pcan_core u_core (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .length_quota(lq_r), .depth_quota(dq_r), .output_capacity(cap_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pcan_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = ACT_APPEND;  // action
  logic [7:0]  in_tdata = '0;          // path_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;              // status
  logic [23:0] out_tdata;              // path_length, out_byte, zero pad
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = REG_LENGTH_QUOTA;
  logic [15:0] cfg_data = '0;

  path_canonicalizer u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // path state tracked alongside the block
  int unsigned len_quota = 0, dep_quota = 0, capacity = 4096;
  logic [7:0]  store [MaxBytes];
  int unsigned comp_start [MaxComponents];
  int unsigned comp_len [MaxComponents];
  int unsigned depth = 0, taken = 0, cur_start = 0, cur_len = 0, cur_dots = 0;
  int unsigned rd_entry = 0, rd_off = 0, canon_len = 0, done_len = 0;
  bit          nul_seen = 0, path_done = 0;
  logic [2:0]  walk_err = ST_NONE, done_st = ST_NONE;

  result_t     pending_q [$];
  int          fails = 0;
  int          n_items = 0, n_ok_paths = 0, n_bytes_read = 0;
  bit          quiet = 0;

  function automatic void close_component();
    if (walk_err == ST_NONE && cur_len != 0 && !(cur_len == 1 && cur_dots == 1)) begin
      if (cur_len == 2 && cur_dots == 2) begin
        if (depth == 0) begin
          walk_err = ST_ESCAPE;
        end else begin
          depth--;
          canon_len -= comp_len[depth] + 1;
        end
      end else if (cur_dots == cur_len) begin
        walk_err = ST_BAD;
      end else if (depth >= MaxComponents) begin
        walk_err = ST_TOO_DEEP;
      end else begin
        comp_start[depth] = cur_start;
        comp_len[depth] = cur_len;
        depth++;
        canon_len += cur_len + 1;
      end
    end
    cur_len = 0;
    cur_dots = 0;
  endfunction

  function automatic result_t canonicalize(logic [1:0] act, logic [7:0] b);
    result_t r;
    r = '0;
    r.status = ST_NONE;
    case (act)
      ACT_APPEND: begin
        if (path_done) begin
          depth = 0; taken = 0; cur_start = 0; cur_len = 0; cur_dots = 0;
          walk_err = ST_NONE; nul_seen = 0; rd_entry = 0; rd_off = 0;
          path_done = 0; canon_len = 0; done_st = ST_NONE; done_len = 0;
        end
        if (taken >= MaxBytes) begin
          taken = MaxBytes + 1;
        end else begin
          store[taken] = b;
          if (b == 8'h00) nul_seen = 1;
          if (b == CH_SLASH) begin
            close_component();
          end else begin
            if (cur_len == 0) cur_start = taken;
            if (b == CH_DOT && cur_dots == cur_len) cur_dots++;
            cur_len++;
          end
          taken++;
        end
      end
      ACT_FINISH: begin
        if (!path_done) begin
          close_component();
          if (len_quota != 0 && taken > len_quota) done_st = ST_TOO_LONG;
          else if (capacity < 2 || taken > MaxBytes || taken + 2 > capacity)
            done_st = ST_TOO_LONG;
          else if (nul_seen) done_st = ST_NUL;
          else if (walk_err != ST_NONE) done_st = walk_err;
          else if (dep_quota != 0 && depth > dep_quota) done_st = ST_TOO_DEEP;
          else if (depth == 0) done_st = ST_EMPTY;
          else if (len_quota != 0 && canon_len > len_quota) done_st = ST_TOO_LONG;
          else done_st = ST_OK;
          done_len = (done_st == ST_OK) ? canon_len : 0;
          path_done = 1;
        end
        rd_entry = 0;
        rd_off = 0;
        r.status = done_st;
        r.path_length = done_len[12:0];
      end
      ACT_READ: begin
        if (path_done && done_st == ST_OK && rd_entry < depth) begin
          r.out_byte = (rd_off == 0) ? CH_SLASH : store[comp_start[rd_entry] + rd_off - 1];
          if (rd_off >= comp_len[rd_entry]) begin
            rd_entry++;
            rd_off = 0;
            r.out_last = (rd_entry == depth);
          end else begin
            rd_off++;
          end
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [7:0] b, bit fixed = 0,
                           result_t fixed_res = '0);
    result_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    r = canonicalize(act, b);
    if (act == ACT_FINISH && r.status == ST_OK) n_ok_paths++;
    if (act == ACT_READ && r.status == ST_OK) n_bytes_read++;
    pending_q.push_back(fixed ? fixed_res : r);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int unsigned lq, int unsigned dq, int unsigned cap);
    logic [15:0] vals [3];
    logic [1:0]  regs [3];
    vals = '{lq[15:0], dq[15:0], cap[15:0]};
    regs = '{REG_LENGTH_QUOTA, REG_DEPTH_QUOTA, REG_CAPACITY};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    len_quota = lq;
    dep_quota = dq;
    capacity = cap;
  endtask

  task automatic send_random_path();
    int n, kind, nlen, nreads;
    logic [7:0] ch;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    n = $urandom_range(0, 6);
    for (int c = 0; c < n; c++) begin
      repeat ($urandom_range(c == 0 ? 0 : 1, 2)) send_item(ACT_APPEND, CH_SLASH);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_item(ACT_APPEND, CH_DOT);
      end else if (kind <= 2) begin
        repeat (2) send_item(ACT_APPEND, CH_DOT);
      end else if (kind == 3) begin
        repeat ($urandom_range(3, 4)) send_item(ACT_APPEND, CH_DOT);
      end else begin
        nlen = $urandom_range(1, 5);
        for (int k = 0; k < nlen; k++) begin
          if ($urandom_range(0, 24) == 0) ch = 8'($urandom);
          else if ($urandom_range(0, 5) == 0) ch = CH_DOT;
          else ch = 8'($urandom_range(8'h41, 8'h7a));
          send_item(ACT_APPEND, ch);
        end
      end
    end
    if ($urandom_range(0, 2) == 0) send_item(ACT_APPEND, CH_SLASH);
    send_item(ACT_FINISH, 8'($urandom));
    nreads = (done_st == ST_OK) ? done_len + $urandom_range(0, 2) : $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) nreads = $urandom_range(0, nreads);
    repeat (nreads) send_item(ACT_READ, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send_item(ACT_FINISH, 8'($urandom));
  endtask

  task automatic run_phase(int unsigned lq, int unsigned dq, int unsigned cap, int paths);
    set_config(lq, dq, cap);
    repeat (paths) send_random_path();
  endtask

  typedef struct {
    logic [1:0]  act;
    logic [7:0]  b;
    bit          fixed;
    logic [2:0]  st;
    logic [12:0] len;
  } row_t;

  row_t dir_rows [33] = '{
    '{ACT_READ,   8'h00,    1, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_EMPTY, 13'd0},
    '{ACT_UNUSED, 8'hff,    1, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_SLASH, 0, ST_NONE,  13'd0},
    '{ACT_APPEND, 8'h61,    0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_SLASH, 0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_SLASH, 0, ST_NONE,  13'd0},
    '{ACT_APPEND, 8'h62,    0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_SLASH, 0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_SLASH, 0, ST_NONE,  13'd0},
    '{ACT_APPEND, 8'h63,    0, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_OK,    13'd4},
    '{ACT_READ,   8'h00,    0, ST_NONE,  13'd0},
    '{ACT_READ,   8'h00,    0, ST_NONE,  13'd0},
    '{ACT_READ,   8'h00,    0, ST_NONE,  13'd0},
    '{ACT_READ,   8'h00,    0, ST_NONE,  13'd0},
    '{ACT_READ,   8'h00,    1, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_OK,    13'd4},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_ESCAPE, 13'd0},
    '{ACT_APPEND, 8'h00,    0, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_NUL,   13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_APPEND, CH_DOT,   0, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_BAD,   13'd0},
    '{ACT_APPEND, 8'hff,    0, ST_NONE,  13'd0},
    '{ACT_FINISH, 8'h00,    1, ST_OK,    13'd2},
    '{ACT_READ,   8'h00,    0, ST_NONE,  13'd0}
  };

  initial begin
    result_t fr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      fr = '0;
      fr.status = dir_rows[i].st;
      fr.path_length = dir_rows[i].len;
      send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].fixed, fr);
    end

    run_phase(0, 0, 4096, 4);
    run_phase(65535, 65535, 65535, 3);
    run_phase(12, 3, 4096, 4);
    run_phase(0, 0, 1, 2);
    run_phase(0, 0, 0, 2);
    run_phase(0, 2, 10, 3);

    // exceed the length quota
    set_config(4, 0, 4096);
    send_item(ACT_APPEND, CH_SLASH);
    for (int k = 0; k < 5; k++) send_item(ACT_APPEND, 8'(8'h61 + k));
    fr = '0;
    fr.status = ST_TOO_LONG;
    send_item(ACT_FINISH, 8'h00, 1, fr);

    // exceed the depth quota
    set_config(0, 1, 4096);
    send_item(ACT_APPEND, CH_SLASH);
    send_item(ACT_APPEND, 8'h71);
    send_item(ACT_APPEND, CH_SLASH);
    send_item(ACT_APPEND, 8'h72);
    fr = '0;
    fr.status = ST_TOO_DEEP;
    send_item(ACT_FINISH, 8'h00, 1, fr);
    send_item(ACT_READ, 8'h00);

    run_phase(0, 0, 4096, 2);
    quiet = 1;
    run_phase(0, 0, 4096, 3);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d transactions: %0d paths canonicalized, %0d bytes read back",
             n_items, n_ok_paths, n_bytes_read);
    $display("config settings swept from zero quotas to maximum, plus length and depth quotas");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d len=%0d byte=%h last=%b", $time,
                 out_tuser, out_tdata[12:0], out_tdata[20:13], out_tlast);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (out_tuser !== want.status || out_tdata[12:0] !== want.path_length ||
            out_tdata[20:13] !== want.out_byte || out_tlast !== want.out_last) begin
          $display("%0t: mismatch expected status=%0d len=%0d byte=%h last=%b", $time,
                   want.status, want.path_length, want.out_byte, want.out_last);
          $display("%0t:          actual   status=%0d len=%0d byte=%h last=%b", $time,
                   out_tuser, out_tdata[12:0], out_tdata[20:13], out_tlast);
          fails++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_q.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
